FILE: sv/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// shared constants and request kind codes for the swinging door compressor
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF  = 4;

  localparam int DEV_BITS    = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam int KIND_BITS = 2;
  localparam logic [KIND_BITS-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_LATER  = 2'd2;

endpackage

FILE: sv/sdc_front.sv
// ----------------------------------------------------------------------------
// sdc_front
// accepts samples, drops those not later in time, tags kept ones by kind
// ----------------------------------------------------------------------------
module sdc_front #(
  parameter int VALUE_BITS = sdc_pkg::VALUE_BITS_DEF,
  parameter int TIME_BITS  = sdc_pkg::TIME_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic [TIME_BITS-1:0]                          in_sample_time,
  input  logic signed [VALUE_BITS-1:0]                  in_sample_value,
  input  logic                                          q_full,
  output logic                                          q_push,
  output logic [sdc_pkg::KIND_BITS+TIME_BITS+VALUE_BITS-1:0] q_data
);

  logic [1:0]                      kept_cnt_r, kept_cnt_nxt;
  logic [TIME_BITS-1:0]            last_time_r, last_time_nxt;
  logic                            accept;
  logic                            keep;
  logic [sdc_pkg::KIND_BITS-1:0]   kind;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    keep = 1'b1;
    kind = sdc_pkg::KIND_LATER;
    if (kept_cnt_r == 2'd0) begin
      kind = sdc_pkg::KIND_FIRST;
    end else if (in_sample_time <= last_time_r) begin
      keep = 1'b0;
    end else if (kept_cnt_r == 2'd1) begin
      kind = sdc_pkg::KIND_SECOND;
    end
  end

  assign q_push = accept && keep;
  assign q_data = {kind, in_sample_time, in_sample_value};

  always_comb begin
    kept_cnt_nxt  = kept_cnt_r;
    last_time_nxt = last_time_r;
    if (q_push) begin
      last_time_nxt = in_sample_time;
      if (kept_cnt_r != 2'd2) begin
        kept_cnt_nxt = kept_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_cnt_r  <= 2'd0;
      last_time_r <= '0;
    end else begin
      kept_cnt_r  <= kept_cnt_nxt;
      last_time_r <= last_time_nxt;
    end
  end

  a_kept_time_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> last_time_r == $past(in_sample_time))
    else $error("last kept time not updated");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

endmodule

FILE: sv/sdc_queue.sv
// ----------------------------------------------------------------------------
// sdc_queue
// short fifo of kept requests between the front and the back
// ----------------------------------------------------------------------------
module sdc_queue #(
  parameter int WIDTH = 2,
  parameter int DEPTH = sdc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entry_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_BITS'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("queue count overflow");

endmodule

FILE: sv/sdc_back.sv
// ----------------------------------------------------------------------------
// sdc_back
// door update, exact slope compare and segment output register
// ----------------------------------------------------------------------------
module sdc_back #(
  parameter int VALUE_BITS = sdc_pkg::VALUE_BITS_DEF,
  parameter int TIME_BITS  = sdc_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS  = sdc_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_wr_en,
  input  logic [sdc_pkg::DEV_BITS-1:0]                  cfg_wr_data,
  input  logic                                          head_valid,
  input  logic [sdc_pkg::KIND_BITS+TIME_BITS+VALUE_BITS-1:0] head_data,
  output logic                                          pop,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic [TIME_BITS-1:0]                          out_start_time,
  output logic signed [VALUE_BITS-1:0]                  out_start_value,
  output logic [TIME_BITS-1:0]                          out_end_time,
  output logic signed [VALUE_BITS-1:0]                  out_end_value
);

  localparam int DEV_BITS  = sdc_pkg::DEV_BITS;
  localparam int RISE_BITS = ((VALUE_BITS > DEV_BITS) ? VALUE_BITS : DEV_BITS) + 2;
  localparam int PROD_BITS = RISE_BITS + TIME_BITS + 1;
  localparam logic [DEV_BITS-1:0] DEV_RESET =
    DEV_BITS'((32'd1 << FRAC_BITS) >> 1);

  logic [DEV_BITS-1:0]          deviation_r;
  logic [TIME_BITS-1:0]         anchor_time_r;
  logic signed [VALUE_BITS-1:0] anchor_value_r;
  logic [TIME_BITS-1:0]         prev_time_r;
  logic signed [VALUE_BITS-1:0] prev_value_r;
  logic signed [RISE_BITS-1:0]  upper_rise_r;
  logic [TIME_BITS-1:0]         upper_run_r;
  logic signed [RISE_BITS-1:0]  lower_rise_r;
  logic [TIME_BITS-1:0]         lower_run_r;
  logic                         closed_r;
  logic                         out_valid_r;
  logic [TIME_BITS-1:0]         out_start_time_r;
  logic signed [VALUE_BITS-1:0] out_start_value_r;
  logic [TIME_BITS-1:0]         out_end_time_r;
  logic signed [VALUE_BITS-1:0] out_end_value_r;

  logic [sdc_pkg::KIND_BITS-1:0] h_kind;
  logic [TIME_BITS-1:0]          h_time;
  logic signed [VALUE_BITS-1:0]  h_value;

  logic signed [RISE_BITS-1:0] v_x, av_x, pv_x, dev_x;
  logic signed [RISE_BITS-1:0] ur, lr, ur2, lr2;
  logic [TIME_BITS-1:0]        run, run2;
  logic signed [TIME_BITS:0]   run_s, urun_s, lrun_s;
  logic signed [PROD_BITS-1:0] p_ur_urun, p_ur_lrun, p_lr_urun, p_lr_lrun;
  logic signed [PROD_BITS-1:0] p_urise_run, p_lrise_run;
  logic                        up_new, lo_new, still_open, dev_zero, emit, out_free;

  assign {h_kind, h_time, h_value} = head_data;

  assign dev_zero = (deviation_r == '0);
  assign v_x   = RISE_BITS'(h_value);
  assign av_x  = RISE_BITS'(anchor_value_r);
  assign pv_x  = RISE_BITS'(prev_value_r);
  assign dev_x = signed'(RISE_BITS'(deviation_r));

  assign ur   = v_x - av_x - dev_x;
  assign lr   = v_x - av_x + dev_x;
  assign run  = h_time - anchor_time_r;
  assign ur2  = v_x - pv_x - dev_x;
  assign lr2  = v_x - pv_x + dev_x;
  assign run2 = h_time - prev_time_r;

  assign run_s  = signed'({1'b0, run});
  assign urun_s = signed'({1'b0, upper_run_r});
  assign lrun_s = signed'({1'b0, lower_run_r});

  assign p_ur_urun   = ur * urun_s;
  assign p_ur_lrun   = ur * lrun_s;
  assign p_lr_urun   = lr * urun_s;
  assign p_lr_lrun   = lr * lrun_s;
  assign p_urise_run = upper_rise_r * run_s;
  assign p_lrise_run = lower_rise_r * run_s;

  assign up_new = p_ur_urun > p_urise_run;
  assign lo_new = p_lr_lrun < p_lrise_run;

  always_comb begin
    case ({up_new, lo_new})
      2'b11:   still_open = !dev_zero;
      2'b10:   still_open = p_ur_lrun < p_lrise_run;
      2'b01:   still_open = p_urise_run < p_lr_urun;
      default: still_open = !closed_r;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = head_valid && out_free;
  assign emit     = pop && (h_kind == sdc_pkg::KIND_LATER) && !still_open;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deviation_r <= DEV_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        deviation_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_start_time_r  <= anchor_time_r;
      out_start_value_r <= anchor_value_r;
      out_end_time_r    <= prev_time_r;
      out_end_value_r   <= prev_value_r;
    end
    if (pop) begin
      unique case (h_kind)
        sdc_pkg::KIND_FIRST: begin
          anchor_time_r  <= h_time;
          anchor_value_r <= h_value;
        end
        sdc_pkg::KIND_SECOND: begin
          upper_rise_r <= ur;
          lower_rise_r <= lr;
          upper_run_r  <= run;
          lower_run_r  <= run;
          closed_r     <= dev_zero;
          prev_time_r  <= h_time;
          prev_value_r <= h_value;
        end
        sdc_pkg::KIND_LATER: begin
          prev_time_r  <= h_time;
          prev_value_r <= h_value;
          if (!still_open) begin
            anchor_time_r  <= prev_time_r;
            anchor_value_r <= prev_value_r;
            upper_rise_r   <= ur2;
            lower_rise_r   <= lr2;
            upper_run_r    <= run2;
            lower_run_r    <= run2;
            closed_r       <= dev_zero;
          end else begin
            closed_r <= 1'b0;
            if (up_new) begin
              upper_rise_r <= ur;
              upper_run_r  <= run;
            end
            if (lo_new) begin
              lower_rise_r <= lr;
              lower_run_r  <= run;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_start_time  = out_start_time_r;
  assign out_start_value = out_start_value_r;
  assign out_end_time    = out_end_time_r;
  assign out_end_value   = out_end_value_r;

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_valid_r && out_stall))
    else $error("segment overwrites a held output");

  a_reanchor_on_prev: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> anchor_time_r == $past(prev_time_r))
    else $error("anchor not moved to previous sample");

  a_open_after_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && h_kind == sdc_pkg::KIND_LATER && still_open) |=> !closed_r)
    else $error("doors marked closed after an open update");

endmodule

FILE: sv/swinging_door_compressor_core.sv
// ----------------------------------------------------------------------------
// swinging_door_compressor_core
// swinging door trending compressor for timestamped Q11.4 samples
// ----------------------------------------------------------------------------
// Samples enter on the in_ channel (valid/stall) and segments leave on the
// out_ channel (valid/stall); a request moves when valid is high and stall is
// low. Each segment carries anchor time/value and the last kept sample.
// The front takes one sample per cycle while in_stall is low, drops samples
// not later than the last kept one and queues the rest in a two-entry fifo.
// The back retires one queued sample per cycle while no held segment blocks
// it. Door slopes are compared combinationally by six 18x33 products, since
// each sample's doors depend on the one before. Segments leave from a register.
// Sustained rate is one sample per clock while out_stall stays low.
// A held segment blocks the back; the fifo then fills and in_stall rises.
// cfg_wr_en writes cfg_wr_data into the deviation register; write it only
// while the block is idle. Synchronous reset (rst_n low) empties the fifo,
// forgets the anchor, clears out_valid and sets the deviation to one half.
// ----------------------------------------------------------------------------
module swinging_door_compressor_core #(
  parameter int VALUE_BITS = sdc_pkg::VALUE_BITS_DEF,
  parameter int TIME_BITS  = sdc_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS  = sdc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [sdc_pkg::DEV_BITS-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [TIME_BITS-1:0]         in_sample_time,
  input  logic signed [VALUE_BITS-1:0] in_sample_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [TIME_BITS-1:0]         out_start_time,
  output logic signed [VALUE_BITS-1:0] out_start_value,
  output logic [TIME_BITS-1:0]         out_end_time,
  output logic signed [VALUE_BITS-1:0] out_end_value
);

  localparam int Q_WIDTH = sdc_pkg::KIND_BITS + TIME_BITS + VALUE_BITS;

  logic               q_full;
  logic               q_push;
  logic [Q_WIDTH-1:0] q_data;
  logic               q_pop;
  logic               q_head_valid;
  logic [Q_WIDTH-1:0] q_head_data;

  sdc_front #(
    .VALUE_BITS (VALUE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_time  (in_sample_time),
    .in_sample_value (in_sample_value),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  sdc_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (sdc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  sdc_back #(
    .VALUE_BITS (VALUE_BITS),
    .TIME_BITS  (TIME_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .head_valid      (q_head_valid),
    .head_data       (q_head_data),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_start_time  (out_start_time),
    .out_start_value (out_start_value),
    .out_end_time    (out_end_time),
    .out_end_value   (out_end_value)
  );

endmodule
